// ===== rtl/pcap_pdu_tlv_stream_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the capture parser
// Concurrent checks on the rising clock edge, masked while in reset.
// ----------------------------------------------------------------------------
`ifndef PCAP_PDU_TLV_STREAM_PARSER_CORE_MACROS_SVH
`define PCAP_PDU_TLV_STREAM_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define PPTSP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PPTSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PPTSP_ASSERT_NOW(name, clk, rst_n, ante, cons)

`define PPTSP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pptsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Capture parser package
// Item types, result kinds, tag codes and sizes shared by the parser modules.
// ----------------------------------------------------------------------------
package pptsp_pkg;

    localparam int NAME_MAX_DEFAULT = 64;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_INFO    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [15:0] TAG_END      = 16'h0000;
    localparam logic [15:0] TAG_NAME     = 16'h000C;
    localparam logic [15:0] TAG_SRC_ADDR = 16'h0014;
    localparam logic [15:0] TAG_DST_ADDR = 16'h0015;
    localparam logic [15:0] TAG_SRC_PORT = 16'h0019;
    localparam logic [15:0] TAG_DST_PORT = 16'h001A;

    localparam logic [15:0] FILE_HDR_LAST = 16'd23;
    localparam logic [15:0] REC_HDR_LAST  = 16'd15;
    localparam logic [15:0] INCL_LEN_LO   = 16'd8;
    localparam logic [15:0] INCL_LEN_HI   = 16'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic [6:0]  name_length;
        logic        frame_last;
        logic        malformed;
    } out_item_t;

    typedef struct packed {
        logic      push;
        out_item_t item;
    } fe_push_t;

endpackage

// ===== rtl/pptsp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pptsp_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/pptsp_front.sv =====
// ----------------------------------------------------------------------------
// Capture parser front end
// Walks file header, record header and TLV fields; classifies each byte.
// ----------------------------------------------------------------------------
module pptsp_front #(
    parameter int NAME_MAX = pptsp_pkg::NAME_MAX_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  pptsp_pkg::in_item_t in_item,
    output pptsp_pkg::fe_push_t fe_push
);
    import pptsp_pkg::*;

    localparam int NCW = $clog2(NAME_MAX + 1);

    localparam logic [2:0] PH_FILE_HDR = 3'd0;
    localparam logic [2:0] PH_REC_HDR  = 3'd1;
    localparam logic [2:0] PH_TAG      = 3'd2;
    localparam logic [2:0] PH_LEN      = 3'd3;
    localparam logic [2:0] PH_VALUE    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD  = 3'd5;

    logic [2:0]     phase_reg, phase_next, ph;
    logic [15:0]    bc_reg, bc_next, bc;
    logic [31:0]    rem_reg, rem_next, rem, rem_dec;
    logic [15:0]    tag_reg, tag_next, tag;
    logic [15:0]    len_reg, len_next, len;
    logic [31:0]    saddr_reg, saddr_next, saddr;
    logic [31:0]    daddr_reg, daddr_next, daddr;
    logic [15:0]    sport_reg, sport_next, sport;
    logic [15:0]    dport_reg, dport_next, dport;
    logic [NCW-1:0] cnt_reg, cnt_next, cnt;
    logic           done_reg, done_next, done;
    logic [NCW+6:0] cnt_wide;
    logic [7:0]     b;
    logic           fs, ended, check_end;
    logic           emit, last, bad;
    logic [1:0]     kind;

    assign b  = in_item.data_byte;
    assign fs = in_item.file_start;

    always_comb
    begin
        ph    = fs ? PH_FILE_HDR : phase_reg;
        bc    = fs ? '0 : bc_reg;
        rem   = fs ? '0 : rem_reg;
        tag   = fs ? '0 : tag_reg;
        len   = fs ? '0 : len_reg;
        saddr = fs ? '0 : saddr_reg;
        daddr = fs ? '0 : daddr_reg;
        sport = fs ? '0 : sport_reg;
        dport = fs ? '0 : dport_reg;
        cnt   = fs ? '0 : cnt_reg;
        done  = fs ? 1'b0 : done_reg;

        phase_next = ph;
        bc_next    = bc;
        rem_next   = rem;
        tag_next   = tag;
        len_next   = len;
        saddr_next = saddr;
        daddr_next = daddr;
        sport_next = sport;
        dport_next = dport;
        cnt_next   = cnt;
        done_next  = done;

        rem_dec   = rem - 32'd1;
        ended     = (rem_dec == '0);
        check_end = 1'b0;
        emit      = 1'b0;
        kind      = KIND_NAME;
        last      = 1'b0;
        bad       = 1'b0;

        unique case (ph)
            PH_FILE_HDR:
            begin
                if (bc >= FILE_HDR_LAST)
                begin
                    phase_next = PH_REC_HDR;
                    bc_next    = '0;
                end
                else
                begin
                    bc_next = bc + 16'd1;
                end
            end
            PH_PAYLOAD:
            begin
                rem_next = rem_dec;
                emit     = 1'b1;
                kind     = KIND_PAYLOAD;
                last     = ended;
                if (ended)
                begin
                    phase_next = PH_REC_HDR;
                    bc_next    = '0;
                end
            end
            PH_TAG:
            begin
                rem_next = rem_dec;
                if (bc == '0)
                begin
                    tag_next  = {b, 8'h00};
                    bc_next   = 16'd1;
                    check_end = 1'b1;
                end
                else
                begin
                    tag_next = {tag[15:8], tag[7:0] | b};
                    bc_next  = '0;
                    if ({tag[15:8], tag[7:0] | b} == TAG_END)
                    begin
                        emit       = 1'b1;
                        kind       = KIND_INFO;
                        last       = ended;
                        phase_next = ended ? PH_REC_HDR : PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                        check_end  = 1'b1;
                    end
                end
            end
            PH_LEN:
            begin
                rem_next  = rem_dec;
                check_end = 1'b1;
                if (bc == '0)
                begin
                    len_next = {b, 8'h00};
                    bc_next  = 16'd1;
                end
                else
                begin
                    len_next = {len[15:8], len[7:0] | b};
                    bc_next  = '0;
                    if ({len[15:8], len[7:0] | b} == '0)
                    begin
                        if (tag == TAG_NAME)
                        begin
                            done_next = 1'b1;
                        end
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                rem_next  = rem_dec;
                check_end = 1'b1;
                if (!ended)
                begin
                    if (tag == TAG_NAME && !done)
                    begin
                        if (b == 8'h00)
                        begin
                            done_next = 1'b1;
                        end
                        else if (cnt < NCW'(NAME_MAX))
                        begin
                            emit     = 1'b1;
                            cnt_next = cnt + 1'b1;
                        end
                    end
                    else if (tag == TAG_SRC_ADDR && bc < 16'd4)
                    begin
                        saddr_next[{~bc[1:0], 3'b000} +: 8] = b;
                    end
                    else if (tag == TAG_DST_ADDR && bc < 16'd4)
                    begin
                        daddr_next[{~bc[1:0], 3'b000} +: 8] = b;
                    end
                    else if (tag == TAG_SRC_PORT && bc == 16'd2)
                    begin
                        sport_next[15:8] = b;
                    end
                    else if (tag == TAG_SRC_PORT && bc == 16'd3)
                    begin
                        sport_next[7:0] = b;
                    end
                    else if (tag == TAG_DST_PORT && bc == 16'd2)
                    begin
                        dport_next[15:8] = b;
                    end
                    else if (tag == TAG_DST_PORT && bc == 16'd3)
                    begin
                        dport_next[7:0] = b;
                    end
                end
                if (({1'b0, bc} + 17'd1) >= {1'b0, len})
                begin
                    bc_next = '0;
                    if (tag == TAG_NAME)
                    begin
                        done_next = 1'b1;
                    end
                    phase_next = PH_TAG;
                end
                else
                begin
                    bc_next = bc + 16'd1;
                end
            end
            default:
            begin
                // record header; unused codes fall back here too
                phase_next = PH_REC_HDR;
                if (bc == '0)
                begin
                    saddr_next = '0;
                    daddr_next = '0;
                    sport_next = '0;
                    dport_next = '0;
                    cnt_next   = '0;
                    done_next  = 1'b0;
                    rem_next   = '0;
                end
                if (bc >= INCL_LEN_LO && bc <= INCL_LEN_HI)
                begin
                    rem_next[{bc[1:0], 3'b000} +: 8] = rem_next[{bc[1:0], 3'b000} +: 8] | b;
                end
                if (bc >= REC_HDR_LAST)
                begin
                    bc_next = '0;
                    if (rem_next == '0)
                    begin
                        emit = 1'b1;
                        kind = KIND_INFO;
                        last = 1'b1;
                        bad  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                else
                begin
                    bc_next = bc + 16'd1;
                end
            end
        endcase

        // record ran out before the end tag
        if (check_end && ended)
        begin
            emit       = 1'b1;
            kind       = KIND_INFO;
            last       = 1'b1;
            bad        = 1'b1;
            phase_next = PH_REC_HDR;
            bc_next    = '0;
        end
    end

    assign cnt_wide = {7'd0, cnt_next};

    always_comb
    begin
        fe_push.push             = in_fire && emit;
        fe_push.item.kind        = kind;
        fe_push.item.out_byte    = (kind == KIND_INFO) ? 8'h00 : b;
        fe_push.item.src_addr    = saddr_next;
        fe_push.item.dst_addr    = daddr_next;
        fe_push.item.src_l4_port = sport_next;
        fe_push.item.dst_l4_port = dport_next;
        fe_push.item.name_length = cnt_wide[6:0];
        fe_push.item.frame_last  = last;
        fe_push.item.malformed   = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FILE_HDR;
            bc_reg    <= '0;
            rem_reg   <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            saddr_reg <= '0;
            daddr_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            rem_reg   <= rem_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            saddr_reg <= saddr_next;
            daddr_reg <= daddr_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== rtl/pptsp_queue.sv =====
// ----------------------------------------------------------------------------
// Capture parser result queue
// Small FIFO between classifier and output stage.
// ----------------------------------------------------------------------------
`include "pcap_pdu_tlv_stream_parser_core_macros.svh"

module pptsp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pptsp_pkg::fe_push_t  fe_push,
    output logic                 q_ready,
    output logic                 q_valid,
    output pptsp_pkg::out_item_t q_item,
    input  logic                 q_pop
);
    import pptsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    out_item_t       mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            full, empty;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign q_ready = !full;
    assign q_valid = !empty;
    assign q_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (fe_push.push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!fe_push.push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe_push.push)
        begin
            mem[wr_ptr_reg] <= fe_push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fe_push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `PPTSP_ASSERT_NOW(a_no_overflow, clk, rst_n, fe_push.push, !full)
    `PPTSP_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, !empty)
    `PPTSP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `PPTSP_ASSERT_NEXT(a_ptr_track, clk, rst_n, fe_push.push && !q_pop, count_reg != '0)

endmodule

// ===== rtl/pptsp_back.sv =====
// ----------------------------------------------------------------------------
// Capture parser output stage
// Pops the queue into the output register and clears unused info fields.
// ----------------------------------------------------------------------------
module pptsp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  pptsp_pkg::out_item_t q_item,
    output logic                 q_pop,
    pptsp_stream_if.source       tx
);
    import pptsp_pkg::*;

    logic      valid_reg;
    out_item_t data_reg, data_next;
    logic      load;

    assign load  = q_valid && (!valid_reg || tx.ready);
    assign q_pop = load;

    always_comb
    begin
        data_next = q_item;
        if (q_item.kind != KIND_INFO)
        begin
            data_next.src_addr    = '0;
            data_next.dst_addr    = '0;
            data_next.src_l4_port = '0;
            data_next.dst_l4_port = '0;
            data_next.name_length = '0;
            data_next.malformed   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign tx.valid   = valid_reg;
    assign tx.payload = data_reg;

endmodule

// ===== rtl/pcap_pdu_tlv_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// Exported-PDU capture stream parser
// Byte-wide capture file in; name bytes, frame info and payload bytes out.
//
//   port  dir  payload                    role
//   rx    in   data_byte, file_start      raw capture bytes
//   tx    out  kind, out_byte, info, last  name / info / payload results
//
// One byte per cycle; each byte gives zero or one result.
// Results pass a 4-entry queue and an output register, so rx stalls only
// when the queue is full.
// Reset puts the parser in file header skip; file_start does the same.
// ----------------------------------------------------------------------------
module pcap_pdu_tlv_stream_parser_core #(
    parameter int NAME_MAX = pptsp_pkg::NAME_MAX_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    pptsp_stream_if.sink   rx,
    pptsp_stream_if.source tx
);
    import pptsp_pkg::*;

    fe_push_t  fe_push;
    logic      q_ready;
    logic      q_valid;
    out_item_t q_item;
    logic      q_pop;
    logic      in_fire;

    assign rx.ready = q_ready;
    assign in_fire  = rx.valid && q_ready;

    pptsp_front #(
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_item (rx.payload),
        .fe_push (fe_push)
    );

    pptsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .fe_push (fe_push),
        .q_ready (q_ready),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    pptsp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .tx      (tx)
    );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the exported-PDU capture stream parser
// Feeds capture files byte by byte through the rx channel: a directed set of
// corner records, then random files of tag-length-value records with random
// truncation, restarts and noise. A parser model in the testbench predicts
// every name byte, frame info and payload byte, and each tx transfer is
// checked field by field in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pptsp_pkg::*;

    localparam int          NAME_LIMIT  = NAME_MAX_DEFAULT;
    localparam int          RAND_BYTES  = 1320;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          TAIL_CYCLES = 20;
    localparam int          MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        PH_FILE_HDR,
        PH_REC_HDR,
        PH_TAG,
        PH_LEN,
        PH_VALUE,
        PH_PAYLOAD
    } parse_phase_e;

    typedef struct {
        in_item_t    item;
        int unsigned gap;
        bit          hold;
    } cap_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    pptsp_stream_if #(.payload_t(in_item_t))  rx_if ();
    pptsp_stream_if #(.payload_t(out_item_t)) tx_if ();

    pcap_pdu_tlv_stream_parser_core #(
        .NAME_MAX(NAME_LIMIT)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    cap_byte_t   capture_bytes[$];
    out_item_t   parsed_results[$];
    logic [7:0]  rec_body[$];
    bit          src_burst;
    bit          hold_next;
    int unsigned bytes_in;
    int unsigned capture_total;
    int unsigned src_wait;
    int unsigned sink_wait;
    bit          sink_calm;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned frames;
    int unsigned bad_frames;
    int unsigned name_bytes;
    int unsigned payload_bytes;

    // parser model state
    parse_phase_e ps_phase;
    logic [15:0]  ps_count;
    logic [31:0]  ps_left;
    logic [15:0]  ps_tag;
    logic [15:0]  ps_len;
    logic [31:0]  ps_src_addr;
    logic [31:0]  ps_dst_addr;
    logic [15:0]  ps_src_l4;
    logic [15:0]  ps_dst_l4;
    logic [6:0]   ps_name_cnt;
    logic         ps_name_done;

    function automatic void clear_frame();
        ps_src_addr  = '0;
        ps_dst_addr  = '0;
        ps_src_l4    = '0;
        ps_dst_l4    = '0;
        ps_name_cnt  = '0;
        ps_name_done = 1'b0;
    endfunction

    function automatic void reset_parser();
        ps_phase = PH_FILE_HDR;
        ps_count = '0;
        ps_left  = '0;
        ps_tag   = '0;
        ps_len   = '0;
        clear_frame();
    endfunction

    function automatic out_item_t frame_info(input logic last, input logic bad);
        out_item_t r;
        r             = '0;
        r.kind        = KIND_INFO;
        r.src_addr    = ps_src_addr;
        r.dst_addr    = ps_dst_addr;
        r.src_l4_port = ps_src_l4;
        r.dst_l4_port = ps_dst_l4;
        r.name_length = ps_name_cnt;
        r.frame_last  = last;
        r.malformed   = bad;
        return r;
    endfunction

    function automatic out_item_t byte_result(input logic [1:0] k, input logic [7:0] b,
                                              input logic last);
        out_item_t r;
        r            = '0;
        r.kind       = k;
        r.out_byte   = b;
        r.frame_last = last;
        return r;
    endfunction

    // One capture byte through the parser model; returns 1 when it yields a result.
    function automatic bit parse_byte(input in_item_t it, output out_item_t res);
        logic [7:0] b;
        logic       ended;
        bit         hit;
        int         idx;
        b   = it.data_byte;
        hit = 1'b0;
        res = '0;
        if (it.file_start)
            reset_parser();

        if (ps_phase == PH_FILE_HDR)
        begin
            if (ps_count == FILE_HDR_LAST)
            begin
                ps_phase = PH_REC_HDR;
                ps_count = '0;
            end
            else
                ps_count++;
            return 1'b0;
        end

        if (ps_phase == PH_REC_HDR)
        begin
            if (ps_count == 0)
            begin
                clear_frame();
                ps_left = '0;
            end
            if (ps_count >= INCL_LEN_LO && ps_count <= INCL_LEN_HI)
                ps_left[8 * (ps_count - INCL_LEN_LO) +: 8] = b;
            if (ps_count == REC_HDR_LAST)
            begin
                ps_count = '0;
                if (ps_left == 0)
                begin
                    res = frame_info(1'b1, 1'b1);
                    return 1'b1;
                end
                ps_phase = PH_TAG;
            end
            else
                ps_count++;
            return 1'b0;
        end

        ps_left--;
        ended = (ps_left == 0);

        case (ps_phase)
            PH_PAYLOAD:
            begin
                res = byte_result(KIND_PAYLOAD, b, ended);
                if (ended)
                begin
                    ps_phase = PH_REC_HDR;
                    ps_count = '0;
                end
                return 1'b1;
            end
            PH_TAG:
            begin
                if (ps_count == 0)
                begin
                    ps_tag   = {b, 8'h00};
                    ps_count = 16'd1;
                end
                else
                begin
                    ps_tag[7:0] = b;
                    ps_count    = '0;
                    if (ps_tag == TAG_END)
                    begin
                        res = frame_info(ended, 1'b0);
                        if (ended)
                            ps_phase = PH_REC_HDR;
                        else
                            ps_phase = PH_PAYLOAD;
                        return 1'b1;
                    end
                    ps_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (ps_count == 0)
                begin
                    ps_len   = {b, 8'h00};
                    ps_count = 16'd1;
                end
                else
                begin
                    ps_len[7:0] = b;
                    ps_count    = '0;
                    if (ps_len == 0)
                    begin
                        if (ps_tag == TAG_NAME)
                            ps_name_done = 1'b1;
                        ps_phase = PH_TAG;
                    end
                    else
                        ps_phase = PH_VALUE;
                end
            end
            default:
            begin
                idx = ps_count;
                if (!ended)
                begin
                    case (ps_tag)
                        TAG_NAME:
                            if (!ps_name_done)
                            begin
                                if (b == 8'h00)
                                    ps_name_done = 1'b1;
                                else if (ps_name_cnt < NAME_LIMIT)
                                begin
                                    res = byte_result(KIND_NAME, b, 1'b0);
                                    ps_name_cnt++;
                                    hit = 1'b1;
                                end
                            end
                        TAG_SRC_ADDR:
                            if (idx < 4)
                                ps_src_addr[8 * (3 - idx) +: 8] = b;
                        TAG_DST_ADDR:
                            if (idx < 4)
                                ps_dst_addr[8 * (3 - idx) +: 8] = b;
                        TAG_SRC_PORT:
                            if (idx == 2)
                                ps_src_l4[15:8] = b;
                            else if (idx == 3)
                                ps_src_l4[7:0] = b;
                        TAG_DST_PORT:
                            if (idx == 2)
                                ps_dst_l4[15:8] = b;
                            else if (idx == 3)
                                ps_dst_l4[7:0] = b;
                        default:
                            ;
                    endcase
                end
                ps_count++;
                if (ps_count >= ps_len)
                begin
                    ps_count = '0;
                    if (ps_tag == TAG_NAME)
                        ps_name_done = 1'b1;
                    ps_phase = PH_TAG;
                end
            end
        endcase

        if (ended)
        begin
            res      = frame_info(1'b1, 1'b1);
            ps_phase = PH_REC_HDR;
            ps_count = '0;
            return 1'b1;
        end
        return hit;
    endfunction

    function automatic string show(input out_item_t r);
        return {$sformatf("kind=%0d byte=%02h src=%08h dst=%08h ",
                          r.kind, r.out_byte, r.src_addr, r.dst_addr),
                $sformatf("sport=%04h dport=%04h nlen=%0d last=%0b bad=%0b",
                          r.src_l4_port, r.dst_l4_port, r.name_length,
                          r.frame_last, r.malformed)};
    endfunction

    function automatic string field_diff(input out_item_t a, input out_item_t b);
        string s;
        s = "";
        if (a.kind !== b.kind)               s = {s, " kind"};
        if (a.out_byte !== b.out_byte)       s = {s, " out_byte"};
        if (a.src_addr !== b.src_addr)       s = {s, " src_addr"};
        if (a.dst_addr !== b.dst_addr)       s = {s, " dst_addr"};
        if (a.src_l4_port !== b.src_l4_port) s = {s, " src_l4_port"};
        if (a.dst_l4_port !== b.dst_l4_port) s = {s, " dst_l4_port"};
        if (a.name_length !== b.name_length) s = {s, " name_length"};
        if (a.frame_last !== b.frame_last)   s = {s, " frame_last"};
        if (a.malformed !== b.malformed)     s = {s, " malformed"};
        return s;
    endfunction

    // ---- stimulus building ----
    task automatic push_byte(input logic [7:0] b, input bit fs);
        cap_byte_t c;
        c.item.data_byte  = b;
        c.item.file_start = fs;
        c.gap             = src_burst ? 0 : $urandom_range(0, 11);
        c.hold            = hold_next;
        hold_next         = 1'b0;
        capture_bytes     = {capture_bytes, c};
    endtask

    task automatic new_file();
        for (int i = 0; i < 24; i++)
            push_byte(8'($urandom_range(0, 255)), i == 0);
    endtask

    // record header carrying incl, then at most incl bytes of the body
    task automatic send_record(input logic [31:0] incl);
        for (int i = 0; i < 16; i++)
            push_byte((i >= 8 && i < 12) ? incl[8 * (i - 8) +: 8]
                                         : 8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < rec_body.size() && i < incl; i++)
            push_byte(rec_body[i], 1'b0);
        rec_body.delete();
    endtask

    task automatic add_hdr(input logic [15:0] tag, input logic [15:0] len);
        rec_body = {rec_body, tag[15:8], tag[7:0], len[15:8], len[7:0]};
    endtask

    task automatic add_bytes(input int n, input int zero_pct);
        logic [7:0] v;
        for (int i = 0; i < n; i++)
        begin
            v        = ($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                          : 8'($urandom_range(1, 255));
            rec_body = {rec_body, v};
        end
    endtask

    task automatic add_tlv(input logic [15:0] tag, input int n, input int zero_pct);
        add_hdr(tag, 16'(n));
        add_bytes(n, zero_pct);
    endtask

    // ---- rx driver ----
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t res;
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.payload <= '0;
            src_wait      <= 0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                bytes_in++;
                if (parse_byte(rx_if.payload, res))
                    parsed_results = {parsed_results, res};
            end
            if (!rx_if.valid || rx_if.ready)
            begin
                if (src_wait != 0)
                begin
                    rx_if.valid <= 1'b0;
                    src_wait    <= src_wait - 1;
                end
                else if (capture_bytes.size() != 0 &&
                         !(capture_bytes[0].hold && parsed_results.size() != 0))
                begin
                    rx_if.valid   <= 1'b1;
                    rx_if.payload <= capture_bytes[0].item;
                    src_wait      <= capture_bytes[0].gap;
                    void'(capture_bytes.pop_front());
                end
                else
                    rx_if.valid <= 1'b0;
            end
        end
    end

    // ---- tx monitor ----
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t got;
        out_item_t want;
        int        d;
        if (!rst_n)
        begin
            tx_if.ready <= 1'b0;
            sink_wait   <= 0;
            sink_calm   <= 1'b0;
        end
        else if (tx_if.valid && tx_if.ready)
        begin
            got = tx_if.payload;
            checked++;
            if (got.kind == KIND_INFO)
            begin
                frames++;
                if (got.malformed)
                    bad_frames++;
            end
            else if (got.kind == KIND_NAME)
                name_bytes++;
            else
                payload_bytes++;

            if (parsed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected transfer: %s", $realtime, show(got));
            end
            else
            begin
                want = parsed_results.pop_front();
                if (field_diff(want, got) != "")
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch in%s", $realtime, field_diff(want, got));
                        $display("    expected %s", show(want));
                        $display("    actual   %s", show(got));
                    end
                end
            end

            d = sink_calm ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 47) == 0)
                sink_calm <= !sink_calm;
            tx_if.ready <= (d == 0);
            sink_wait   <= d;
        end
        else if (sink_wait > 1)
        begin
            sink_wait   <= sink_wait - 1;
            tx_if.ready <= 1'b0;
        end
        else
        begin
            sink_wait   <= 0;
            tx_if.ready <= 1'b1;
        end
    end

    // ---- watchdog ----
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ---- stimulus and end of run ----
    initial
    begin
        int unsigned next_hold;
        int          n_tlv;
        int          roll;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.payload = '0;
        tx_if.ready   = 1'b0;
        reset_parser();

        // directed corners
        src_burst = 1'b1;
        new_file();

        // every tag kind, extreme addresses and ports, payload extremes
        add_hdr(TAG_NAME, 16'd4);
        rec_body = {rec_body, 8'h61, 8'h62, 8'h00, 8'h7A};
        add_hdr(TAG_SRC_ADDR, 16'd4);
        rec_body = {rec_body, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_hdr(TAG_DST_ADDR, 16'd6);
        rec_body = {rec_body, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h55, 8'hAA};
        add_hdr(TAG_SRC_PORT, 16'd4);
        rec_body = {rec_body, 8'h12, 8'h34, 8'hFF, 8'hFF};
        add_hdr(TAG_DST_PORT, 16'd4);
        rec_body = {rec_body, 8'hFF, 8'hFF, 8'h00, 8'h00};
        add_tlv(16'h1234, 3, 0);
        add_tlv(TAG_NAME, 3, 0);
        rec_body = {rec_body, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h5A};
        send_record(rec_body.size());

        // empty record, then end tag as the final byte
        send_record(0);
        rec_body = {rec_body, 8'h00, 8'h00};
        send_record(2);

        // empty name closes naming; short address and port values, an overlong port
        src_burst = 1'b0;
        add_hdr(TAG_NAME, 16'd0);
        add_tlv(TAG_NAME, 3, 0);
        add_hdr(TAG_SRC_ADDR, 16'd2);
        rec_body = {rec_body, 8'hC0, 8'hA8};
        add_hdr(TAG_SRC_PORT, 16'd2);
        rec_body = {rec_body, 8'h11, 8'h22};
        add_hdr(TAG_DST_PORT, 16'd6);
        rec_body = {rec_body, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
        add_tlv(16'h010C, 1, 0);
        rec_body = {rec_body, 8'h00, 8'h00};
        add_bytes(1, 0);
        send_record(rec_body.size());

        // name longer than the limit
        add_tlv(TAG_NAME, NAME_LIMIT + 6, 0);
        rec_body = {rec_body, 8'h00, 8'h00};
        send_record(rec_body.size());

        // records cut inside a tag, a length, a name value, a huge length
        add_tlv(TAG_SRC_ADDR, 4, 0);
        send_record(1);
        add_tlv(TAG_SRC_ADDR, 4, 0);
        send_record(3);
        add_tlv(TAG_NAME, 5, 0);
        send_record(7);
        add_hdr(16'hFFFF, 16'hFFFF);
        add_bytes(4, 0);
        send_record(8);

        // open-ended record dropped by a new file, restart inside the file header
        add_tlv(TAG_NAME, 3, 0);
        send_record(32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++)
            push_byte(8'($urandom_range(0, 255)), i == 0);
        new_file();
        add_tlv(TAG_DST_ADDR, 4, 0);
        rec_body = {rec_body, 8'h00, 8'h00};
        add_bytes(2, 0);
        send_record(rec_body.size());

        // random files; parser drained before the random part and every few hundred bytes
        hold_next = 1'b1;
        next_hold = capture_bytes.size() + 300;
        while (capture_bytes.size() < RAND_BYTES)
        begin
            if (capture_bytes.size() >= next_hold)
            begin
                hold_next = 1'b1;
                next_hold += 300;
            end
            if ($urandom_range(0, 5) == 0)
                src_burst = !src_burst;
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                repeat ($urandom_range(1, 24))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                new_file();
            end
            else if (roll < 12)
                new_file();

            n_tlv = $urandom_range(0, 5);
            repeat (n_tlv)
            begin
                case ($urandom_range(0, 5))
                    0: add_tlv(TAG_NAME, ($urandom_range(0, 29) == 0) ? $urandom_range(60, 72)
                                                                     : $urandom_range(0, 8), 10);
                    1: add_tlv(TAG_SRC_ADDR, $urandom_range(0, 6), 5);
                    2: add_tlv(TAG_DST_ADDR, $urandom_range(0, 6), 5);
                    3: add_tlv(TAG_SRC_PORT, $urandom_range(0, 6), 5);
                    4: add_tlv(TAG_DST_PORT, $urandom_range(0, 6), 5);
                    default: add_tlv(16'($urandom_range(1, 65535)), $urandom_range(0, 5), 10);
                endcase
            end
            if ($urandom_range(0, 9) != 0)
            begin
                rec_body = {rec_body, 8'h00, 8'h00};
                add_bytes($urandom_range(0, 12), 10);
            end
            roll = $urandom_range(0, 99);
            if (roll < 85 || rec_body.size() == 0)
                send_record(rec_body.size());
            else if (roll < 93)
                send_record($urandom_range(1, rec_body.size()));
            else
                send_record(0);
        end
        capture_total = capture_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_in < capture_total)
            @(posedge clk);
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d capture bytes; checked %0d results: %0d frames (%0d malformed),",
                 bytes_in, checked, frames, bad_frames);
        $display("%0d name bytes, %0d payload bytes, %0d mismatches",
                 name_bytes, payload_bytes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
